@@ src/apt3d_pkg.sv @@
package apt3d_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CoefCount = 12;
  localparam int unsigned Rows      = 3;
  localparam int unsigned Cols      = 4;
  localparam int unsigned ProdW     = 2 * DataW;
  // Three full products plus the scaled translation never need more than 66 bits.
  localparam int unsigned AccW      = ProdW + 2;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_XFORM = 1'b1
  } action_e;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef struct packed {
    action_e             action;
    logic [IdxW-1:0]     coef_index;
    logic signed [31:0]  coef_value;
    logic signed [31:0]  in_x;
    logic signed [31:0]  in_y;
    logic signed [31:0]  in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic                overflow;
  } out_item_t;

  // Load strobes for the two stages inside each row unit.
  typedef struct packed {
    logic part_load;
    logic out_load;
  } row_ctl_t;

endpackage

@@ src/apt3d_coef_mul.sv @@
module apt3d_coef_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [apt3d_pkg::IdxW-1:0]  wr_idx_i,
  input  apt3d_pkg::data_t            wr_val_i,
  input  logic                        load_i,
  input  apt3d_pkg::data_t            x_i,
  input  apt3d_pkg::data_t            y_i,
  input  apt3d_pkg::data_t            z_i,
  output apt3d_pkg::prod_t            prod_o [apt3d_pkg::Rows][3],
  output apt3d_pkg::data_t            trans_o [apt3d_pkg::Rows]
);
  import apt3d_pkg::*;

  data_t coef_q [CoefCount];
  prod_t prod_q [Rows][3];
  data_t trans_q [Rows];
  data_t pt [3];

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoefCount; i++) begin
        coef_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      coef_q[wr_idx_i] <= wr_val_i;
    end
  end

  // One 32x32 signed multiplier per entry of the 3x3 linear part; products and translations all registered.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int r = 0; r < Rows; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_t'(coef_q[r*Cols+c]) * prod_t'(pt[c]);
        end
        trans_q[r] <= coef_q[r*Cols+3];
      end
    end
  end

  assign prod_o  = prod_q;
  assign trans_o = trans_q;

endmodule

@@ src/apt3d_row_acc.sv @@
module apt3d_row_acc #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  apt3d_pkg::row_ctl_t  ctl_i,
  input  apt3d_pkg::prod_t     p0_i,
  input  apt3d_pkg::prod_t     p1_i,
  input  apt3d_pkg::prod_t     p2_i,
  input  apt3d_pkg::data_t     trans_i,
  output apt3d_pkg::data_t     res_o,
  output logic                 sat_o
);
  import apt3d_pkg::*;

  typedef logic signed [AccW-1:0] acc_t;

  localparam acc_t RoundK = (FRAC_BITS > 0) ? (acc_t'(1) <<< (FRAC_BITS - 1)) : acc_t'(0);

  acc_t  part_a_q, part_b_q;
  acc_t  sum, shifted;
  logic  pos_ovf, neg_ovf;
  data_t res_q, res_d;
  logic  sat_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.part_load) begin
      part_a_q <= acc_t'(p0_i) + acc_t'(p1_i);
      part_b_q <= acc_t'(p2_i) + (acc_t'(trans_i) <<< FRAC_BITS) + RoundK;
    end
  end

  assign sum     = part_a_q + part_b_q;
  assign shifted = sum >>> FRAC_BITS;

  // The value fits when every bit above the 32-bit sign position matches the sign.
  assign pos_ovf = !shifted[AccW-1] && (|shifted[AccW-2:DataW-1]);
  assign neg_ovf = shifted[AccW-1] && !(&shifted[AccW-2:DataW-1]);

  always_comb begin
    res_d = shifted[DataW-1:0];
    if (pos_ovf) begin
      res_d = {1'b0, {(DataW-1){1'b1}}};
    end else if (neg_ovf) begin
      res_d = {1'b1, {(DataW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      res_q <= res_d;
      sat_q <= pos_ovf | neg_ovf;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

@@ src/affine_point_transform_3d.sv @@
// Four-stage pipeline: input register, products, partial sums with rounding, final sum with saturation.
// Throughput: one item per cycle while out_stall_i is low, set by nine parallel 32x32 multipliers in the product stage.
// A coefficient write is consumed when it leaves the input register and gives no result.
// Reset clears all stage valid bits and sets the twelve coefficients to zero.
module affine_point_transform_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  apt3d_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output apt3d_pkg::out_item_t  out_item_o
);
  import apt3d_pkg::*;

  logic     v1_q, v2_q, v3_q, v4_q;
  logic     v1_d, v2_d, v3_d, v4_d;
  logic     rdy1, rdy2, rdy3, rdy4;
  logic     adv1, wr_en, mul_load;
  in_item_t in_q;
  row_ctl_t row_ctl;
  prod_t    prod [Rows][3];
  data_t    trans [Rows];
  data_t    res [Rows];
  logic     sat [Rows];

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  assign adv1     = v1_q && rdy2;
  assign wr_en    = adv1 && (in_q.action == ACT_WRITE) &&
                    (in_q.coef_index < IdxW'(CoefCount));
  assign mul_load = adv1 && (in_q.action == ACT_XFORM);

  assign row_ctl.part_load = v2_q && rdy3;
  assign row_ctl.out_load  = v3_q && rdy4;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? (v1_q && (in_q.action == ACT_XFORM)) : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      in_q <= in_item_i;
    end
  end

  apt3d_coef_mul u_coef_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_idx_i (in_q.coef_index),
    .wr_val_i (in_q.coef_value),
    .load_i   (mul_load),
    .x_i      (in_q.in_x),
    .y_i      (in_q.in_y),
    .z_i      (in_q.in_z),
    .prod_o   (prod),
    .trans_o  (trans)
  );

  for (genvar r = 0; r < Rows; r++) begin : g_row
    apt3d_row_acc #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row_acc (
      .clk_i   (clk_i),
      .ctl_i   (row_ctl),
      .p0_i    (prod[r][0]),
      .p1_i    (prod[r][1]),
      .p2_i    (prod[r][2]),
      .trans_i (trans[r]),
      .res_o   (res[r]),
      .sat_o   (sat[r])
    );
  end

  assign out_valid_o         = v4_q;
  assign out_item_o.out_x    = res[0];
  assign out_item_o.out_y    = res[1];
  assign out_item_o.out_z    = res[2];
  assign out_item_o.overflow = sat[0] | sat[1] | sat[2];

  // The input side only stalls while the input register holds an item that cannot move on.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with an empty input register");

  // With the output side free, every stage can move, so the input never stalls.
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side accepts");

  // A full tail that is stalled must keep its partial-sum item.
  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && out_stall_i) |=> v3_q)
    else $error("partial-sum stage lost an item under stall");

endmodule

@@ dv/affine_point_transform_3d_tb.sv @@
`timescale 1ns / 1ps

module affine_point_transform_3d_tb;
  import apt3d_pkg::*;

  localparam int          FracBits      = 16;
  localparam int          ClkPeriod     = 10;
  localparam int          LatencyCycles = 8;
  localparam int          CycleLimit    = 200_000;
  localparam int          RandomItems   = 1420;
  localparam int          MaxPrinted    = 50;
  localparam data_t       MaxData       = 32'sh7FFF_FFFF;
  localparam data_t       MinData       = 32'sh8000_0000;
  localparam data_t       Unity         = 32'sh0001_0000;
  localparam logic signed [79:0] SumMax = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SumMin = -80'sh8000_0000;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  data_t     coef_store [CoefCount] = '{default: '0};
  out_item_t pending_points [$];
  out_item_t want_point;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        stall_left     = 0;
  bit        idle_on        = 1'b1;

  affine_point_transform_3d #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxPrinted) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Exact sum of the three products and the scaled translation, then round and clip.
  function automatic out_item_t transform_point(data_t x, data_t y, data_t z);
    logic signed [79:0] acc;
    logic signed [79:0] c;
    logic signed [79:0] v;
    data_t              row_out [Rows];
    logic               sat;
    out_item_t          res;
    sat = 1'b0;
    for (int r = 0; r < Rows; r++) begin
      c   = coef_store[r*Cols];
      v   = x;
      acc = c * v;
      c   = coef_store[r*Cols+1];
      v   = y;
      acc = acc + c * v;
      c   = coef_store[r*Cols+2];
      v   = z;
      acc = acc + c * v;
      c   = coef_store[r*Cols+3];
      acc = acc + (c <<< FracBits);
      if (FracBits > 0) acc = acc + (80'sd1 <<< (FracBits - 1));
      acc = acc >>> FracBits;
      if (acc > SumMax) begin
        row_out[r] = MaxData;
        sat = 1'b1;
      end else if (acc < SumMin) begin
        row_out[r] = MinData;
        sat = 1'b1;
      end else begin
        row_out[r] = acc[31:0];
      end
    end
    res.out_x    = row_out[0];
    res.out_y    = row_out[1];
    res.out_z    = row_out[2];
    res.overflow = sat;
    return res;
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0, 1: rand_value = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: rand_value = MaxData;
          1: rand_value = MinData;
          2: rand_value = '0;
          3: rand_value = 32'sd1;
          default: rand_value = -32'sd1;
        endcase
      end
      // Mostly values within +/-4.0 so that results stay in range.
      default: rand_value = data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic send_item(in_item_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk_i); while (in_stall);
    if (item.action == ACT_XFORM) begin
      pending_points.push_back(transform_point(item.in_x, item.in_y, item.in_z));
    end else if (item.coef_index < CoefCount) begin
      coef_store[item.coef_index] = item.coef_value;
    end
  endtask

  task automatic load_coef(int unsigned idx, data_t value);
    in_item_t item;
    item.action     = ACT_WRITE;
    item.coef_index = IdxW'(idx);
    item.coef_value = value;
    item.in_x       = $urandom;
    item.in_y       = $urandom;
    item.in_z       = $urandom;
    send_item(item);
  endtask

  task automatic push_point(data_t x, data_t y, data_t z);
    in_item_t item;
    item.action     = ACT_XFORM;
    item.coef_index = IdxW'($urandom_range(0, 15));
    item.coef_value = $urandom;
    item.in_x       = x;
    item.in_y       = y;
    item.in_z       = z;
    send_item(item);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // The matrix comes out of reset as all zero, so any point maps to the origin.
  task automatic test_cleared_matrix();
    push_point(MaxData, MaxData, MaxData);
    push_point(MinData, MinData, MinData);
  endtask

  task automatic test_saturation();
    load_coef(0 * Cols + 0, Unity);
    load_coef(1 * Cols + 1, Unity);
    load_coef(2 * Cols + 2, Unity);
    push_point(MaxData, MinData, '0);
    load_coef(0 * Cols + 3, MaxData);
    push_point(MaxData, '0, '0);
    load_coef(1 * Cols + 3, MinData);
    push_point('0, MinData, '0);
    load_coef(0 * Cols + 0, MinData);
    load_coef(0 * Cols + 1, MinData);
    push_point(MinData, MinData, MinData);
  endtask

  // A one-LSB coefficient exposes the half-way cases of the rounding.
  task automatic test_rounding();
    load_coef(0 * Cols + 0, 32'sd1);
    load_coef(0 * Cols + 1, '0);
    load_coef(0 * Cols + 2, '0);
    load_coef(0 * Cols + 3, '0);
    push_point(32'sh0000_8000, '0, '0);
    push_point(-32'sh0000_8000, '0, '0);
    push_point(32'sh0000_7FFF, '0, '0);
    push_point(-32'sh0000_8001, '0, '0);
  endtask

  task automatic test_bad_index();
    for (int unsigned idx = CoefCount; idx < (1 << IdxW); idx++) load_coef(idx, MaxData);
    push_point(Unity, -Unity, MaxData);
  endtask

  task automatic test_random_stream();
    int pick;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      // Let the pipeline empty once with traffic on both sides of the pause.
      if (n == RandomItems / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 60) push_point(rand_value(), rand_value(), rand_value());
      else if (pick < 92) load_coef($urandom_range(0, CoefCount - 1), rand_value());
      else load_coef($urandom_range(0, 15), rand_value());
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("result transfer with no transform pending");
      end else begin
        want_point = pending_points.pop_front();
        if (out_item.out_x !== want_point.out_x)
          report_mismatch($sformatf("out_x got %h want %h", out_item.out_x, want_point.out_x));
        if (out_item.out_y !== want_point.out_y)
          report_mismatch($sformatf("out_y got %h want %h", out_item.out_y, want_point.out_y));
        if (out_item.out_z !== want_point.out_z)
          report_mismatch($sformatf("out_z got %h want %h", out_item.out_z, want_point.out_z));
        if (out_item.overflow !== want_point.overflow)
          report_mismatch($sformatf("overflow got %b want %b", out_item.overflow,
                                    want_point.overflow));
      end
      stall_left = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_cleared_matrix();
    wait_for_results();
    test_saturation();
    test_rounding();
    test_bad_index();
    test_random_stream();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
